// ===== rtl/ptjd_pkg.sv =====
package ptjd_pkg;

   localparam int TIME_W    = 64;
   localparam int NOW_W     = 63;
   localparam int CNT_W     = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_JUMP    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE    = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_VALID_COUNT = CSR_IDX_W'(2);

   typedef struct packed {
      logic [NOW_W-1:0]  max_jump_ns;
      logic [TIME_W:0]   jump_limit;     // 2^64 - max_jump_ns
      logic [NOW_W-1:0]  debounce_ns;
      logic [CNT_W-1:0]  valid_frames_needed;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0] ingress_time;
      logic [TIME_W-1:0] origin_time;
      logic [TIME_W-1:0] skew;           // ingress_time - origin_time
      logic              is_synced;
      logic [NOW_W-1:0]  now_time;
      logic              in_future_flag;
      logic              in_past_flag;
   } item_type;

   typedef struct packed {
      logic jump_future;
      logic jump_past;
   } result_type;

endpackage

// ===== rtl/ptjd_if.sv =====
interface ptjd_req_if;
   logic                            valid;
   logic                            ready;
   logic [ptjd_pkg::TIME_W-1:0]     ingress_time;
   logic [ptjd_pkg::TIME_W-1:0]     origin_time;
   logic                            is_synced;
   logic [ptjd_pkg::NOW_W-1:0]      now_time;
   logic                            in_future_flag;
   logic                            in_past_flag;

   modport source (
      output valid, ingress_time, origin_time, is_synced, now_time,
             in_future_flag, in_past_flag,
      input  ready
   );
   modport sink (
      input  valid, ingress_time, origin_time, is_synced, now_time,
             in_future_flag, in_past_flag,
      output ready
   );
endinterface

interface ptjd_rsp_if;
   logic valid;
   logic ready;
   logic jump_future;
   logic jump_past;

   modport source (output valid, jump_future, jump_past, input ready);
   modport sink   (input valid, jump_future, jump_past, output ready);
endinterface

interface ptjd_csr_if;
   logic                               valid;
   logic                               ready;
   logic [ptjd_pkg::CSR_IDX_W-1:0]     index;
   logic [ptjd_pkg::CSR_DAT_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/ptjd_csr.sv =====
module ptjd_csr (
   input  logic                clock,
   input  logic                reset,
   ptjd_csr_if.sink            csr_chan,
   output ptjd_pkg::cfg_type   cfg
);

   ptjd_pkg::cfg_type cfg_ff, cfg_in;
   logic              write;
   logic [ptjd_pkg::NOW_W-1:0] wdata63;

   assign csr_chan.ready = 1'b1;
   assign write          = csr_chan.valid && csr_chan.ready;
   assign wdata63        = csr_chan.data[ptjd_pkg::NOW_W-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         unique case (csr_chan.index)
            ptjd_pkg::CSR_MAX_JUMP: begin
               cfg_in.max_jump_ns = wdata63;
               cfg_in.jump_limit  = {1'b1, {ptjd_pkg::TIME_W{1'b0}}}
                                    - {2'b00, wdata63};
            end
            ptjd_pkg::CSR_DEBOUNCE: begin
               cfg_in.debounce_ns = wdata63;
            end
            ptjd_pkg::CSR_VALID_COUNT: begin
               cfg_in.valid_frames_needed = csr_chan.data[ptjd_pkg::CNT_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_jump_ns         <= '0;
         cfg_ff.jump_limit          <= {1'b1, {ptjd_pkg::TIME_W{1'b0}}};
         cfg_ff.debounce_ns         <= '0;
         cfg_ff.valid_frames_needed <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/ptjd_detect.sv =====
module ptjd_detect (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  ptjd_pkg::item_type    item,
   input  ptjd_pkg::cfg_type     cfg,
   output ptjd_pkg::result_type  result
);

   typedef enum logic [1:0] {
      MODE_IDLE     = 2'd0,
      MODE_DEBOUNCE = 2'd1,
      MODE_HANDLING = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_FUTURE = 2'd1,
      KIND_PAST   = 2'd2
   } kind_type;

   mode_type                     mode_ff, mode_in;
   kind_type                     kind_ff, kind_in;
   logic                         have_last_ff, have_last_in;
   logic [ptjd_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [ptjd_pkg::TIME_W-1:0]  last_ingress_ff, last_ingress_in;
   logic [ptjd_pkg::TIME_W-1:0]  last_skew_ff, last_skew_in;
   logic [ptjd_pkg::NOW_W-1:0]   start_ff, start_in;

   logic [ptjd_pkg::TIME_W-1:0]  delta;
   logic                         rising, ahead, behind, past_jump, future_jump;
   logic [ptjd_pkg::CNT_W-1:0]   count_inc;
   logic [ptjd_pkg::TIME_W-1:0]  deadline;

   // delta = predicted origin - received origin, modulo 2^64
   assign delta       = item.skew - last_skew_ff;
   assign rising      = item.ingress_time > last_ingress_ff;
   assign ahead       = (delta != '0) && (delta <= ~item.origin_time);
   assign behind      = (delta != '0) && !ahead;
   assign past_jump   = rising && ahead
                        && (delta > {1'b0, cfg.max_jump_ns});
   assign future_jump = rising && behind
                        && ({1'b0, delta} < cfg.jump_limit);
   assign count_inc   = (count_ff == '1) ? count_ff : count_ff + 1'b1;
   assign deadline    = {1'b0, start_ff} + {1'b0, cfg.debounce_ns};

   always_comb begin
      mode_in         = mode_ff;
      kind_in         = kind_ff;
      have_last_in    = have_last_ff;
      count_in        = count_ff;
      last_ingress_in = last_ingress_ff;
      last_skew_in    = last_skew_ff;
      start_in        = start_ff;
      result.jump_future = item.in_future_flag;
      result.jump_past   = item.in_past_flag;
      unique case (mode_ff)
         MODE_HANDLING: begin
            if (have_last_ff) begin
               if (past_jump || future_jump) begin
                  kind_in  = past_jump ? KIND_PAST : KIND_FUTURE;
                  count_in = '0;
               end else begin
                  count_in = count_inc;
                  if (count_inc >= cfg.valid_frames_needed) begin
                     kind_in = KIND_NONE;
                  end
               end
            end
            have_last_in    = 1'b1;
            last_ingress_in = item.ingress_time;
            last_skew_in    = item.skew;
            unique case (kind_in)
               KIND_NONE: begin
                  result.jump_future = 1'b0;
                  result.jump_past   = 1'b0;
               end
               KIND_FUTURE: begin
                  result.jump_future = 1'b1;
                  result.jump_past   = 1'b0;
               end
               KIND_PAST: begin
                  result.jump_future = 1'b0;
                  result.jump_past   = 1'b1;
               end
               default: begin
                  result.jump_future = item.in_future_flag;
                  result.jump_past   = item.in_past_flag;
               end
            endcase
         end
         MODE_DEBOUNCE: begin
            if (deadline < {1'b0, item.now_time}) begin
               mode_in = MODE_HANDLING;
            end
         end
         default: begin
            if (item.is_synced) begin
               start_in = item.now_time;
               mode_in  = MODE_DEBOUNCE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_IDLE;
         kind_ff         <= KIND_NONE;
         have_last_ff    <= 1'b0;
         count_ff        <= '0;
         last_ingress_ff <= '0;
         last_skew_ff    <= '0;
         start_ff        <= '0;
      end else if (advance) begin
         mode_ff         <= mode_in;
         kind_ff         <= kind_in;
         have_last_ff    <= have_last_in;
         count_ff        <= count_in;
         last_ingress_ff <= last_ingress_in;
         last_skew_ff    <= last_skew_in;
         start_ff        <= start_in;
      end
   end

endmodule

// ===== rtl/ptp_time_jump_detector.sv =====
// PTP time jump detector.
// req_chan carries one sync frame per transaction: ingress and origin
// timestamps, the synchronized status, the local debounce clock time and the
// incoming jump flags. rsp_chan returns exactly one transaction per frame with
// the jump_future / jump_past flags, in frame order.
// csr_chan writes the configuration: index 0 max_jump_ns, 1 debounce_ns,
// 2 valid_frames_needed; other indexes are ignored. It is always ready and
// should only be written while no frame is in flight.
// A frame moves from the frame stage register to the result register, which
// drives rsp_chan. Throughput: one frame per cycle when rsp_chan is ready;
// the path from the input register through the 64-bit predicted-origin
// subtract and limit compares to the result register sets the clock.
// A frame stage register and a result register decouple the two sides: while
// rsp_chan is stalled, one more frame is taken and held, then req_chan.ready
// drops until the result is taken.
// Reset (synchronous) empties both registers, returns the mode to idle, clears
// the jump state and the good-frame count and zeroes the configuration.
module ptp_time_jump_detector (
   input  logic        clock,
   input  logic        reset,
   ptjd_req_if.sink    req_chan,
   ptjd_rsp_if.source  rsp_chan,
   ptjd_csr_if.sink    csr_chan
);

   ptjd_pkg::cfg_type    cfg;
   ptjd_pkg::item_type   item_ff, item_in;
   ptjd_pkg::result_type result, result_ff;
   logic                 in_valid_ff, in_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free, advance, accept;

   ptjd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   ptjd_detect u_detect (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      item_in.ingress_time   = req_chan.ingress_time;
      item_in.origin_time    = req_chan.origin_time;
      item_in.skew           = req_chan.ingress_time - req_chan.origin_time;
      item_in.is_synced      = req_chan.is_synced;
      item_in.now_time       = req_chan.now_time;
      item_in.in_future_flag = req_chan.in_future_flag;
      item_in.in_past_flag   = req_chan.in_past_flag;
      in_valid_in  = accept || (in_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.jump_future = result_ff.jump_future;
   assign rsp_chan.jump_past   = result_ff.jump_past;

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("frame left stage without producing a result");

   a_stalled_frame_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(item_ff))
      else $error("stalled frame lost or changed");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> in_valid_ff)
      else $error("accepted frame not held in stage");

   a_empty_stage_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_chan.ready)
      else $error("empty stage refuses frames");

endmodule

// ===== tb/ptjd_jump_checker.sv =====
`timescale 1ns / 1ps

module ptjd_jump_checker (
   input  logic        clock,
   input  logic        reset,
   ptjd_req_if         req_chan,
   ptjd_rsp_if         rsp_chan,
   ptjd_csr_if         csr_chan,
   output int unsigned mismatch_count,
   output int unsigned frames_in_flight
);

   localparam int TIME_W = ptjd_pkg::TIME_W;
   localparam int NOW_W  = ptjd_pkg::NOW_W;
   localparam int CNT_W  = ptjd_pkg::CNT_W;

   typedef enum logic [1:0] {SYNC_WAIT, SETTLING, TRACKING} track_mode_type;
   typedef enum logic [1:0] {NO_JUMP, JUMP_FWD, JUMP_BACK} jump_kind_type;

   logic [NOW_W-1:0]     lim_ns;
   logic [NOW_W-1:0]     settle_ns;
   logic [CNT_W-1:0]     clear_after;
   track_mode_type       mode;
   logic                 have_prev;
   logic [TIME_W-1:0]    prev_ingress;
   logic [TIME_W-1:0]    prev_origin;
   logic [NOW_W-1:0]     settle_start;
   jump_kind_type        jump_state;
   logic [CNT_W-1:0]     good_run;
   ptjd_pkg::result_type flag_q[$];
   int unsigned          rsp_seen = 0;
   int unsigned          miscompares = 0;

   assign mismatch_count = miscompares;

   task automatic report_mismatch(input string msg);
      $display("%0t: ptjd result %0d: %s", $time, rsp_seen, msg);
      miscompares++;
   endtask

   function automatic ptjd_pkg::result_type predict_flags(
      input logic [TIME_W-1:0] ingress,
      input logic [TIME_W-1:0] origin,
      input logic              synced,
      input logic [NOW_W-1:0]  now,
      input logic              fut_in,
      input logic              past_in
   );
      ptjd_pkg::result_type r;
      logic [TIME_W-1:0]    guess;
      logic                 jumped;
      r.jump_future = fut_in;
      r.jump_past   = past_in;
      case (mode)
         TRACKING: begin
            if (have_prev) begin
               jumped = 1'b0;
               if (ingress > prev_ingress) begin
                  guess = prev_origin + (ingress - prev_ingress);
                  if (guess > origin && guess - origin > TIME_W'(lim_ns)) begin
                     jump_state = JUMP_BACK;
                     jumped     = 1'b1;
                  end else if (guess < origin && origin - guess > TIME_W'(lim_ns)) begin
                     jump_state = JUMP_FWD;
                     jumped     = 1'b1;
                  end
               end
               if (jumped) begin
                  good_run = '0;
               end else begin
                  if (good_run != {CNT_W{1'b1}}) good_run = good_run + 1'b1;
                  if (good_run >= clear_after) jump_state = NO_JUMP;
               end
            end
            have_prev    = 1'b1;
            prev_ingress = ingress;
            prev_origin  = origin;
            r.jump_future = (jump_state == JUMP_FWD);
            r.jump_past   = (jump_state == JUMP_BACK);
         end
         SETTLING: begin
            if (TIME_W'(settle_start) + TIME_W'(settle_ns) < TIME_W'(now)) mode = TRACKING;
         end
         default: begin
            if (synced) begin
               settle_start = now;
               mode         = SETTLING;
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      ptjd_pkg::result_type want;
      if (reset) begin
         lim_ns       = '0;
         settle_ns    = '0;
         clear_after  = '0;
         mode         = SYNC_WAIT;
         have_prev    = 1'b0;
         prev_ingress = '0;
         prev_origin  = '0;
         settle_start = '0;
         jump_state   = NO_JUMP;
         good_run     = '0;
         flag_q.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_seen++;
            if (flag_q.size() == 0) begin
               report_mismatch("transaction with no frame outstanding");
            end else begin
               want = flag_q.pop_front();
               if (rsp_chan.jump_future !== want.jump_future) begin
                  report_mismatch($sformatf("jump_future %0b, expected %0b",
                                            rsp_chan.jump_future, want.jump_future));
               end
               if (rsp_chan.jump_past !== want.jump_past) begin
                  report_mismatch($sformatf("jump_past %0b, expected %0b",
                                            rsp_chan.jump_past, want.jump_past));
               end
            end
         end
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_chan.index)
               ptjd_pkg::CSR_MAX_JUMP:    lim_ns      = csr_chan.data[NOW_W-1:0];
               ptjd_pkg::CSR_DEBOUNCE:    settle_ns   = csr_chan.data[NOW_W-1:0];
               ptjd_pkg::CSR_VALID_COUNT: clear_after = csr_chan.data[CNT_W-1:0];
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            flag_q.push_back(predict_flags(req_chan.ingress_time, req_chan.origin_time,
                                           req_chan.is_synced, req_chan.now_time,
                                           req_chan.in_future_flag, req_chan.in_past_flag));
         end
      end
      frames_in_flight <= flag_q.size();
   end

endmodule

// ===== tb/tb_ptp_time_jump_detector.sv =====
`timescale 1ns / 1ps

module tb_ptp_time_jump_detector;

   localparam int TIME_W    = ptjd_pkg::TIME_W;
   localparam int NOW_W     = ptjd_pkg::NOW_W;
   localparam int CNT_W     = ptjd_pkg::CNT_W;
   localparam int CSR_IDX_W = ptjd_pkg::CSR_IDX_W;
   localparam int CSR_DAT_W = ptjd_pkg::CSR_DAT_W;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = CSR_IDX_W'(3);
   localparam logic [NOW_W-1:0]     NOW_MAX   = '1;
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned HOLD_CYCLES = 120;

   typedef struct {
      logic [NOW_W-1:0] max_jump;
      logic [NOW_W-1:0] debounce;
      logic [CNT_W-1:0] need;
      int unsigned      jump_pct;
      int unsigned      noise_pct;
      int unsigned      send_idle;
      int unsigned      recv_idle;
      int unsigned      items;
   } phase_type;

   logic clock;
   logic reset;
   logic hold_rsp;
   int unsigned mismatch_count;
   int unsigned frames_in_flight;
   int unsigned send_idle_pct = 10;
   int unsigned recv_idle_pct = 46;
   int unsigned idle_cycles = 0;
   logic [TIME_W-1:0] last_ingress_sent = '0;
   logic [TIME_W-1:0] last_origin_sent = '0;
   event hold_start;

   ptjd_req_if req_chan ();
   ptjd_rsp_if rsp_chan ();
   ptjd_csr_if csr_chan ();

   ptp_time_jump_detector DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   ptjd_jump_checker u_jump_check (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_chan         (csr_chan),
      .mismatch_count   (mismatch_count),
      .frames_in_flight (frames_in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      hold_rsp = 1'b0;
      forever begin
         @(hold_start);
         hold_rsp <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_rsp <= 1'b0;
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             (csr_chan.valid && csr_chan.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_ptp_time_jump_detector: FAIL");
            $finish;
         end
      end
   end

   function automatic logic [TIME_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [NOW_W-1:0] rand_now();
      logic [TIME_W-1:0] v;
      v = rand64();
      return v[NOW_W-1:0];
   endfunction

   task automatic wait_drained();
      do @(posedge clock); while (frames_in_flight != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= val;
      do @(posedge clock); while (!csr_chan.ready);
   endtask

   // only between phases, with no frame in the block
   task automatic write_settings(input logic [NOW_W-1:0] max_jump,
                                 input logic [NOW_W-1:0] debounce,
                                 input logic [CNT_W-1:0] need);
      logic [TIME_W-1:0] noise;
      req_chan.valid <= 1'b0;
      wait_drained();
      noise = rand64();
      put_reg(ptjd_pkg::CSR_MAX_JUMP, {1'($urandom_range(1)), max_jump});
      put_reg(ptjd_pkg::CSR_DEBOUNCE, {1'($urandom_range(1)), debounce});
      put_reg(ptjd_pkg::CSR_VALID_COUNT, {noise[TIME_W-1:CNT_W], need});
      put_reg(CSR_SPARE, rand64());
      csr_chan.valid <= 1'b0;
   endtask

   task automatic send_frame(input logic [TIME_W-1:0] ingress,
                             input logic [TIME_W-1:0] origin,
                             input logic              synced,
                             input logic [NOW_W-1:0]  now,
                             input logic              fut,
                             input logic              past);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.ingress_time   <= ingress;
      req_chan.origin_time    <= origin;
      req_chan.is_synced      <= synced;
      req_chan.now_time       <= now;
      req_chan.in_future_flag <= fut;
      req_chan.in_past_flag   <= past;
      do @(posedge clock); while (!req_chan.ready);
      last_ingress_sent = ingress;
      last_origin_sent  = origin;
   endtask

   // origin is placed mag away from last origin plus the ingress step
   task automatic send_tracked(input logic [TIME_W-1:0] delta,
                               input logic [TIME_W-1:0] mag,
                               input logic              back);
      logic [TIME_W-1:0] guess;
      guess = last_origin_sent + delta;
      send_frame(last_ingress_sent + delta, back ? guess - mag : guess + mag,
                 1'($urandom_range(1)), rand_now(), 1'($urandom_range(1)),
                 1'($urandom_range(1)));
   endtask

   task automatic run_directed();
      write_settings(63'd100, NOW_MAX, 8'd2);
      send_frame('1, '1, 1'b0, NOW_MAX, 1'b1, 1'b0);
      send_frame('0, '0, 1'b0, '0, 1'b0, 1'b1);
      send_frame(64'd10, 64'd20, 1'b1, 63'd1000, 1'b1, 1'b1);
      send_frame(64'd30, 64'd40, 1'b0, NOW_MAX, 1'b0, 1'b0);
      send_frame(64'd50, 64'd60, 1'b1, '0, 1'b1, 1'b1);
      write_settings(63'd100, '0, 8'd2);
      send_frame(64'd70, 64'd80, 1'b0, 63'd1000, 1'b1, 1'b0);
      send_frame(64'd90, 64'd99, 1'b1, 63'd1001, 1'b0, 1'b1);
      send_frame(64'd1000, 64'd5000, 1'b0, '0, 1'b1, 1'b1);
      send_tracked(64'd100, 64'd0, 1'b0);
      send_tracked(64'd100, 64'd100, 1'b0);
      send_tracked(64'd100, 64'd100, 1'b1);
      send_tracked(64'd100, 64'd101, 1'b0);
      send_tracked(64'd100, 64'd101, 1'b1);
      send_tracked(64'd100, 64'd0, 1'b0);
      send_tracked(64'd100, 64'd0, 1'b0);
      send_tracked(64'd0, 64'd12345, 1'b0);
      send_frame(last_ingress_sent - 64'd5, rand64(), 1'b1, rand_now(), 1'b1, 1'b0);
      send_frame(64'd5000, '1 - 64'd49, 1'b0, rand_now(), 1'b0, 1'b1);
      send_tracked(64'd100, 64'd0, 1'b0);
      write_settings('0, '0, '0);
      send_tracked(64'd1000, 64'd1, 1'b1);
      send_tracked(64'd1000, 64'd0, 1'b0);
      send_frame('1, rand64(), 1'b1, rand_now(), 1'b1, 1'b1);
      send_tracked(64'd1, 64'd0, 1'b0);
   endtask

   task automatic run_phase(input phase_type ph, input int unsigned k);
      logic [TIME_W-1:0] span;
      logic [TIME_W-1:0] delta;
      logic [TIME_W-1:0] mag;
      int unsigned       pick;
      write_settings(ph.max_jump, ph.debounce, ph.need);
      send_idle_pct = ph.send_idle;
      recv_idle_pct = ph.recv_idle;
      span = TIME_W'(ph.max_jump) + 64'd1;
      send_tracked(TIME_W'($urandom_range(1, 1 << 20)), span, 1'($urandom_range(1)));
      for (int unsigned n = 1; n < ph.items; n++) begin
         if (n == ph.items / 2 && k == 1) -> hold_start;
         if (n == ph.items / 2 && k == 3) begin
            req_chan.valid <= 1'b0;
            wait_drained();
         end
         pick  = $urandom_range(99);
         delta = TIME_W'($urandom_range(1, 1 << 20));
         if (pick < ph.noise_pct) begin
            send_frame(rand64(), rand64(), 1'($urandom_range(1)), rand_now(),
                       1'($urandom_range(1)), 1'($urandom_range(1)));
         end else if (pick < ph.noise_pct + 6) begin
            send_frame(last_ingress_sent - TIME_W'($urandom_range(0, 3)), rand64(),
                       1'($urandom_range(1)), rand_now(), 1'($urandom_range(1)),
                       1'($urandom_range(1)));
         end else if (pick < ph.noise_pct + 12) begin
            send_tracked(rand64() >> 1, rand64() % span, 1'($urandom_range(1)));
         end else if ($urandom_range(99) < ph.jump_pct) begin
            mag = span + (rand64() >> $urandom_range(1, 63));
            send_tracked(delta, mag, 1'($urandom_range(1)));
         end else begin
            if ($urandom_range(9) == 0) mag = TIME_W'(ph.max_jump);
            else mag = (rand64() >> $urandom_range(0, 63)) % span;
            send_tracked(delta, mag, 1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      phase_type plan [6];
      reset                   = 1'b1;
      req_chan.valid          = 1'b0;
      req_chan.ingress_time   = '0;
      req_chan.origin_time    = '0;
      req_chan.is_synced      = 1'b0;
      req_chan.now_time       = '0;
      req_chan.in_future_flag = 1'b0;
      req_chan.in_past_flag   = 1'b0;
      csr_chan.valid          = 1'b0;
      csr_chan.index          = '0;
      csr_chan.data           = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      plan[0] = '{63'd1000, rand_now(), 8'd3, 10, 8, 10, 46, 250};
      plan[1] = '{'0, rand_now(), 8'd0, 10, 8, 10, 46, 250};
      plan[2] = '{NOW_MAX, NOW_MAX, 8'd255, 10, 10, 46, 10, 250};
      plan[3] = '{rand_now() >> 23, rand_now(), 8'($urandom_range(1, 254)), 10, 8, 46, 10, 250};
      plan[4] = '{63'd50, '0, 8'd255, 0, 0, 0, 0, 300};
      plan[5] = '{63'd1, rand_now(), 8'd1, 15, 5, 0, 0, 230};

      run_directed();
      foreach (plan[k]) run_phase(plan[k], k);

      req_chan.valid <= 1'b0;
      wait_drained();
      if (mismatch_count == 0) begin
         $display("tb_ptp_time_jump_detector: PASS");
      end else begin
         $display("tb_ptp_time_jump_detector: FAIL");
      end
      $finish;
   end

endmodule
